FILE: rtl/svm_pkg.sv
`default_nettype none

package svm_pkg;

  // field and register widths
  localparam int EDGE_W   = 16;
  localparam int VOLT_W   = 16;
  localparam int FS_W     = 10;
  localparam int FS10_W   = FS_W + 4;
  localparam int FILT_W   = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // conversion constants
  localparam int unsigned ZERO_COUNT  = 250;
  localparam int unsigned SPAN_COUNT  = 200;
  localparam int unsigned VOLT_SCALE  = 10;
  localparam int          DECIMATION_DEF = 16;

  // register reset values
  localparam logic [EDGE_W-1:0] FAULT_LOW_RST  = 16'd40;
  localparam logic [EDGE_W-1:0] FAULT_HIGH_RST = 16'd500;
  localparam logic [FS_W-1:0]   FULL_SCALE_RST = 10'd450;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FAULT_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FAULT_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_COMB1,
    ST_COMB2,
    ST_COMB3,
    ST_CONV,
    ST_DIV_SPAN,
    ST_MUL,
    ST_DIV_GAIN,
    ST_SAT,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

FILE: rtl/svm_in_if.sv
`default_nettype none

interface svm_in_if import svm_pkg::*;;
  logic              valid;
  logic              ready;
  logic [EDGE_W-1:0] edge_count;

  modport source (output valid, output edge_count, input ready);
  modport sink   (input valid, input edge_count, output ready);
endinterface

`default_nettype wire

FILE: rtl/svm_out_if.sv
`default_nettype none

interface svm_out_if import svm_pkg::*;;
  logic              valid;
  logic              ready;
  logic [VOLT_W-1:0] volts_100mv;
  logic              new_value;
  logic              sensor_fault;

  modport source (output valid, output volts_100mv, output new_value, output sensor_fault,
                  input ready);
  modport sink   (input valid, input volts_100mv, input new_value, input sensor_fault,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/svm_cfg_if.sv
`default_nettype none

interface svm_cfg_if import svm_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/sinc3_decimating_voltage_meter.sv
// Sequencing: an ordinary beat goes straight to the result register; a frame-closing beat
//   first runs three comb steps, convert, three shared-multiplier passes and saturate.
// Flow: one beat at a time, in_ch.ready high only when idle; a clamped frame-closing beat
//   skips passes and saturate; no new beat is taken while the result waits on out_ch.ready.
// Reset (rst_n low, synchronous): filter state, counters and held voltage clear, registers
//   return to fault limits 40 / 500 and full scale 450 volts, the output register empties.
`default_nettype none

module sinc3_decimating_voltage_meter import svm_pkg::*; #(
  parameter int DECIMATION = DECIMATION_DEF
) (
  input  wire        clk,
  input  wire        rst_n,
  svm_in_if.sink     in_ch,
  svm_out_if.source  out_ch,
  svm_cfg_if.sink    cfg_ch
);

  // CIC gain and conversion sizing, derived from the decimation ratio and conversion constants
  localparam int unsigned GAIN   = DECIMATION * DECIMATION * DECIMATION;
  localparam int unsigned ZERO   = GAIN * ZERO_COUNT;
  localparam int ZERO_W = $clog2(ZERO + 1);
  localparam int Q_W    = $clog2(ZERO / SPAN_COUNT + 1);
  // full_scale*10*q
  localparam int PROD_W = FS10_W + Q_W;
  localparam int DEC_W  = $clog2(DECIMATION);

  // Both divisions are by constants: multiply by a rounded-up reciprocal and keep the
  // high bits. With l = clog2(d) and a shift of N+l, the quotient is exact for any
  // dividend below 2^N.
  localparam int SPAN_SH = ZERO_W + $clog2(SPAN_COUNT);
  localparam longint unsigned SPAN_M =
    ((64'd1 << SPAN_SH) + 64'(SPAN_COUNT) - 64'd1) / 64'(SPAN_COUNT);
  localparam int GAIN_SH = PROD_W + $clog2(GAIN);
  localparam longint unsigned GAIN_M =
    ((64'd1 << GAIN_SH) + 64'(GAIN) - 64'd1) / 64'(GAIN);

  // shared multiplier: A takes the dividend or full_scale*10, B the reciprocal or q
  localparam int MA_W = PROD_W;
  localparam int MB_W = PROD_W + 1;
  localparam int MP_W = MA_W + MB_W;
  localparam int V_W  = MP_W - GAIN_SH;
  localparam int unsigned VOLT_MAX = 2**VOLT_W - 1;

  state_t state_r, state_nxt;

  // configuration registers
  logic [EDGE_W-1:0] lo_r, hi_r;
  logic [FS_W-1:0]   fs_r;

  // CIC state: integrators, comb delays, comb scratch
  logic [FILT_W-1:0] int0_r, int1_r, int2_r;
  logic [FILT_W-1:0] cd0_r, cd1_r, cd2_r;
  logic [FILT_W-1:0] s_r;
  logic [DEC_W-1:0]  decim_r;
  logic [VOLT_W-1:0] held_r;
  logic              fault_r;
  logic              fresh_r;

  // conversion: distance below the zero point, multiplier product
  logic [ZERO_W-1:0] x_r;
  logic [MP_W-1:0]   mp_r;

  // output register
  logic              out_valid_r;
  logic [VOLT_W-1:0] out_volts_r;
  logic              out_new_r;
  logic              out_fault_r;

  logic in_fire, out_fire, cfg_fire, out_load;

  logic [MA_W-1:0]   mul_a;
  logic [MB_W-1:0]   mul_b;
  logic [MP_W-1:0]   mul_p;
  logic [V_W-1:0]    volts_raw;
  logic              volts_sat;

  logic [FS10_W-1:0] fs10;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_fire  = in_ch.valid & in_ch.ready;
  assign cfg_fire = cfg_ch.valid & cfg_ch.ready;
  assign out_fire = out_ch.valid & out_ch.ready;

  assign out_ch.valid        = out_valid_r;
  assign out_ch.volts_100mv  = out_volts_r;
  assign out_ch.new_value    = out_new_r;
  assign out_ch.sensor_fault = out_fault_r;

  // the result register frees up either when empty or when its beat is taken
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || out_ch.ready);

  assign fs10 = FS10_W'(fs_r) * FS10_W'(VOLT_SCALE);

  // operand select for the shared multiplier, one pass per state
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_DIV_SPAN: begin
        mul_a = MA_W'(x_r);
        mul_b = MB_W'(SPAN_M);
      end
      ST_MUL: begin
        mul_a = MA_W'(fs10);
        mul_b = MB_W'(mp_r[SPAN_SH +: Q_W]);
      end
      ST_DIV_GAIN: begin
        mul_a = MA_W'(mp_r[PROD_W-1:0]);
        mul_b = MB_W'(GAIN_M);
      end
      default: ;
    endcase
  end

  assign mul_p     = MP_W'(mul_a) * MP_W'(mul_b);
  assign volts_raw = mp_r[MP_W-1:GAIN_SH];
  assign volts_sat = (volts_raw > V_W'(VOLT_MAX));

  // sequencer: next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = (decim_r == DEC_W'(DECIMATION - 1)) ? ST_COMB1 : ST_DONE;
        end
      end
      ST_COMB1:    state_nxt = ST_COMB2;
      ST_COMB2:    state_nxt = ST_COMB3;
      ST_COMB3:    state_nxt = ST_CONV;
      ST_CONV:     state_nxt = (s_r > FILT_W'(ZERO)) ? ST_DONE : ST_DIV_SPAN;
      ST_DIV_SPAN: state_nxt = ST_MUL;
      ST_MUL:      state_nxt = ST_DIV_GAIN;
      ST_DIV_GAIN: state_nxt = ST_SAT;
      ST_SAT:      state_nxt = ST_DONE;
      ST_DONE:     state_nxt = out_load ? ST_IDLE : ST_DONE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // configuration writes; unknown indexes drop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_r <= FAULT_LOW_RST;
      hi_r <= FAULT_HIGH_RST;
      fs_r <= FULL_SCALE_RST;
    end else if (cfg_fire) begin
      case (cfg_ch.index)
        CFG_FAULT_LOW:  lo_r <= cfg_ch.data;
        CFG_FAULT_HIGH: hi_r <= cfg_ch.data;
        CFG_FULL_SCALE: fs_r <= cfg_ch.data[FS_W-1:0];
        default: ;
      endcase
    end
  end

  // filter and conversion datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      int0_r  <= '0;
      int1_r  <= '0;
      int2_r  <= '0;
      cd0_r   <= '0;
      cd1_r   <= '0;
      cd2_r   <= '0;
      decim_r <= '0;
      held_r  <= '0;
      fault_r <= 1'b0;
      fresh_r <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            fault_r <= (in_ch.edge_count < lo_r) || (in_ch.edge_count > hi_r);
            // each stage adds the old value of the stage before it
            int2_r  <= int2_r + int1_r;
            int1_r  <= int1_r + int0_r;
            int0_r  <= int0_r + FILT_W'(in_ch.edge_count);
            if (decim_r == DEC_W'(DECIMATION - 1)) begin
              decim_r <= '0;
              fresh_r <= 1'b1;
            end else begin
              decim_r <= decim_r + DEC_W'(1);
              fresh_r <= 1'b0;
            end
          end
        end
        ST_COMB1: begin
          s_r   <= int2_r - cd0_r;
          cd0_r <= int2_r;
        end
        ST_COMB2: begin
          s_r   <= s_r - cd1_r;
          cd1_r <= s_r;
        end
        ST_COMB3: begin
          s_r   <= s_r - cd2_r;
          cd2_r <= s_r;
        end
        ST_CONV: begin
          if (s_r > FILT_W'(ZERO)) begin
            // count above the zero point: clamp rather than wrap
            held_r <= '0;
          end else begin
            x_r <= ZERO_W'(ZERO) - s_r[ZERO_W-1:0];
          end
        end
        // q = x / 200, then full_scale*10*q, then that over the CIC gain
        ST_DIV_SPAN, ST_MUL, ST_DIV_GAIN: begin
          mp_r <= mul_p;
        end
        ST_SAT: begin
          held_r <= volts_sat ? {VOLT_W{1'b1}} : VOLT_W'(volts_raw);
        end
        default: ;
      endcase
    end
  end

  // output register: hold the beat until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_volts_r <= held_r;
      out_new_r   <= fresh_r;
      out_fault_r <= fault_r;
    end
  end

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ch.ready)
    else $error("input accepted while previous beat still in work");

  a_mul_pass_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV_SPAN) |=> (state_r == ST_MUL))
    else $error("multiplier passes out of order");

  a_held_update_path: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(held_r) |-> ($past(state_r) == ST_SAT || $past(state_r) == ST_CONV))
    else $error("held voltage changed outside conversion");

  a_fresh_only_on_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && fresh_r |-> decim_r == '0)
    else $error("new value flagged without a completed decimation frame");
`endif

endmodule

`default_nettype wire

FILE: tb/sv/svm_meter_checker.sv
`default_nettype none

module svm_meter_checker import svm_pkg::*; #(
  parameter int DECIMATION = DECIMATION_DEF
) (
  input  wire clk,
  input  wire rst_n,
  svm_in_if   in_mon,
  svm_out_if  out_mon,
  svm_cfg_if  cfg_mon,
  output int  mismatches,
  output int  pending
);

  localparam longint unsigned GAIN       = DECIMATION * DECIMATION * DECIMATION;
  localparam longint unsigned ZERO_POINT = GAIN * ZERO_COUNT;

  typedef struct packed {
    logic [VOLT_W-1:0] volts;
    logic              fresh;
    logic              fault;
  } reading_t;

  reading_t expected_readings[$];

  logic [EDGE_W-1:0] fault_low;
  logic [EDGE_W-1:0] fault_high;
  logic [FS_W-1:0]   full_scale;
  logic [FILT_W-1:0] integ [3];
  logic [FILT_W-1:0] comb_dly [3];
  int unsigned       decim_cnt;
  logic [VOLT_W-1:0] held_volts;

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("%0t: %s: want %0d got %0d", $time, what, want, got);
    mismatches++;
  endtask

  // Comb output to 100 mV units; counts above the zero point clamp to 0.
  function automatic logic [VOLT_W-1:0] to_decivolts(input logic [FILT_W-1:0] filt,
                                                     input logic [FS_W-1:0] fs);
    longint unsigned q;
    longint unsigned v;
    if (64'(filt) > ZERO_POINT) return '0;
    q = (ZERO_POINT - 64'(filt)) / SPAN_COUNT;
    v = (64'(fs) * (VOLT_SCALE * q)) / GAIN;
    if (v > 65535) v = 65535;
    return v[VOLT_W-1:0];
  endfunction

  task automatic predict_reading(input logic [EDGE_W-1:0] cnt, output reading_t r);
    logic [FILT_W-1:0] s1;
    logic [FILT_W-1:0] s2;
    logic [FILT_W-1:0] s3;
    r.fault = (cnt < fault_low) || (cnt > fault_high);
    r.fresh = 1'b0;
    // each stage adds the old value of the stage ahead of it
    integ[2] = integ[2] + integ[1];
    integ[1] = integ[1] + integ[0];
    integ[0] = integ[0] + FILT_W'(cnt);
    decim_cnt++;
    if (decim_cnt >= DECIMATION) begin
      s1 = integ[2] - comb_dly[0];
      comb_dly[0] = integ[2];
      s2 = s1 - comb_dly[1];
      comb_dly[1] = s1;
      s3 = s2 - comb_dly[2];
      comb_dly[2] = s2;
      held_volts = to_decivolts(s3, full_scale);
      decim_cnt = 0;
      r.fresh = 1'b1;
    end
    r.volts = held_volts;
  endtask

  always @(posedge clk) begin
    reading_t want;
    if (!rst_n) begin
      fault_low  = FAULT_LOW_RST;
      fault_high = FAULT_HIGH_RST;
      full_scale = FULL_SCALE_RST;
      for (int k = 0; k < 3; k++) begin
        integ[k]    = '0;
        comb_dly[k] = '0;
      end
      decim_cnt  = 0;
      held_volts = '0;
      expected_readings.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          CFG_FAULT_LOW:  fault_low  = cfg_mon.data[EDGE_W-1:0];
          CFG_FAULT_HIGH: fault_high = cfg_mon.data[EDGE_W-1:0];
          CFG_FULL_SCALE: full_scale = cfg_mon.data[FS_W-1:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        predict_reading(in_mon.edge_count, want);
        expected_readings.push_back(want);
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_readings.size() == 0) begin
          report_mismatch("result beat with no reading expected", 32'd0,
                          32'(out_mon.volts_100mv));
        end else begin
          want = expected_readings.pop_front();
          if (out_mon.volts_100mv !== want.volts)
            report_mismatch("volts_100mv", 32'(want.volts), 32'(out_mon.volts_100mv));
          if (out_mon.new_value !== want.fresh)
            report_mismatch("new_value", 32'(want.fresh), 32'(out_mon.new_value));
          if (out_mon.sensor_fault !== want.fault)
            report_mismatch("sensor_fault", 32'(want.fault), 32'(out_mon.sensor_fault));
        end
      end
    end
    pending = expected_readings.size();
  end

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
`default_nettype none

module testbench;
  import svm_pkg::*;

  // no beat on any channel for this many cycles ends the run
  localparam int STALL_LIMIT = 2000;
  // settle time after the last reading: covers the longest frame-closing beat
  localparam int TAIL_CYCLES = 80;
  localparam int FRAME_LEN   = 16;
  localparam int PHASE_FRAMES = 20;
  // index that maps to no register; writes to it must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  logic clk;
  logic rst_n;
  int   mismatches;
  int   pending;
  int   quiet_cycles;

  // idling switches, redrawn per frame so that quiet stretches occur too
  logic in_gaps_on    = 1'b0;
  logic out_stalls_on = 1'b0;

  // our copy of the fault window, used to aim counts at its edges
  logic [EDGE_W-1:0] win_low;
  logic [EDGE_W-1:0] win_high;
  int                level;

  // directed counts: field extremes, both sides of each window edge,
  // alternating bit patterns, the zero point and just above it, then 100s
  logic [EDGE_W-1:0] directed_counts [25] = '{
    16'd0, 16'hFFFF, 16'd39, 16'd40, 16'd41, 16'd499, 16'd500, 16'd501,
    16'h5555, 16'hAAAA, 16'd250, 16'd251,
    16'd100, 16'd100, 16'd100, 16'd100, 16'd100, 16'd100, 16'd100,
    16'd100, 16'd100, 16'd100, 16'd100, 16'd100, 16'd100
  };

  svm_in_if  in_ch ();
  svm_out_if out_ch ();
  svm_cfg_if cfg_ch ();

  sinc3_decimating_voltage_meter i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  svm_meter_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .cfg_mon    (cfg_ch),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Push one edge count; enter and leave at a falling edge. Valid stays high
  // on return so a back-to-back beat needs no second assignment.
  task automatic send_count(input logic [EDGE_W-1:0] cnt);
    int gap;
    gap = in_gaps_on ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.edge_count <= cnt;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    @(negedge clk);
  endtask

  // Drop input valid and hold until every predicted reading has come back.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Write all three registers, then a stray write to the unused index last so
  // that a decode error would stick and show up in the next phase.
  task automatic program_regs(input logic [EDGE_W-1:0] lo, input logic [EDGE_W-1:0] hi,
                              input logic [CFG_DATA_W-1:0] fs_word);
    logic [CFG_IDX_W-1:0]  idx  [4];
    logic [CFG_DATA_W-1:0] word [4];
    idx  = '{CFG_FAULT_LOW, CFG_FAULT_HIGH, CFG_FULL_SCALE, CFG_UNUSED};
    word = '{lo, hi, fs_word, CFG_DATA_W'($urandom)};
    for (int k = 0; k < 4; k++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= idx[k];
      cfg_ch.data  <= word[k];
      do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
      @(negedge clk);
    end
    cfg_ch.valid <= 1'b0;
    win_low  = lo;
    win_high = hi;
  endtask

  // Random frames. Mostly a slowly moving level near the meter's working
  // range; the rest is uniform counts up to 300, wide noise (drives the
  // integrators through wrap) and counts at and by the fault window edges.
  task automatic run_frames(input int nframes);
    int style;
    int v;
    logic [EDGE_W-1:0] cnt;
    for (int f = 0; f < nframes; f++) begin
      in_gaps_on    = ($urandom_range(0, 3) != 0);
      out_stalls_on = ($urandom_range(0, 3) != 0);
      style = $urandom_range(0, 99);
      if ($urandom_range(0, 9) < 3) level = $urandom_range(0, 260);
      for (int k = 0; k < FRAME_LEN; k++) begin
        if (style < 55) begin
          v = level + int'($urandom_range(0, 16)) - 8;
          if (v < 0) v = 0;
          cnt = EDGE_W'(v);
        end else if (style < 70) begin
          cnt = EDGE_W'($urandom_range(0, 300));
        end else if (style < 85) begin
          cnt = EDGE_W'($urandom_range(0, 65535));
        end else begin
          case ($urandom_range(0, 3))
            0: cnt = win_low - EDGE_W'(1);
            1: cnt = win_low;
            2: cnt = win_high;
            default: cnt = win_high + EDGE_W'(1);
          endcase
        end
        send_count(cnt);
      end
    end
  endtask

  // Result side: draw a stall per beat, then hold ready until a beat moves.
  initial begin
    int n;
    out_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      n = out_stalls_on ? $urandom_range(0, 7) : 0;
      if (n > 0) begin
        out_ch.ready <= 1'b0;
        repeat (n) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
      @(negedge clk);
    end
  end

  // Watchdog: count cycles in which no beat moves on any channel.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("sinc3_decimating_voltage_meter: mismatch");
      $finish;
    end
  end

  initial begin
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.edge_count = '0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = CFG_FAULT_LOW;
    cfg_ch.data      = '0;
    win_low          = FAULT_LOW_RST;
    win_high         = FAULT_HIGH_RST;
    level            = 100;

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset defaults, directed counts
    foreach (directed_counts[i]) send_count(directed_counts[i]);
    wait_drained();

    // open window, largest full scale
    program_regs(16'd0, 16'hFFFF, 16'h03FF);
    run_frames(PHASE_FRAMES);
    wait_drained();

    // inverted window, smallest nonzero full scale
    program_regs(16'hFFFF, 16'd0, 16'h0001);
    run_frames(PHASE_FRAMES);
    wait_drained();

    // full scale written with only upper bits set: masks to zero volts
    program_regs(16'd40, 16'd500, 16'hFC00);
    run_frames(PHASE_FRAMES);
    wait_drained();

    // everything random, upper data bits included
    program_regs(EDGE_W'($urandom), EDGE_W'($urandom), CFG_DATA_W'($urandom));
    run_frames(PHASE_FRAMES);
    wait_drained();

    // back to the power-up values
    program_regs(FAULT_LOW_RST, FAULT_HIGH_RST, CFG_DATA_W'(FULL_SCALE_RST));
    run_frames(PHASE_FRAMES);
    wait_drained();

    // a window somewhere in the working range, random scale
    program_regs(EDGE_W'($urandom_range(0, 300)), EDGE_W'($urandom_range(0, 600)),
                 CFG_DATA_W'($urandom_range(1, 1023)));
    run_frames(PHASE_FRAMES);
    wait_drained();

    // let any stray beat surface before the verdict
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatches == 0)
      $display("sinc3_decimating_voltage_meter: match");
    else
      $display("sinc3_decimating_voltage_meter: mismatch");
    $finish;
  end

endmodule

`default_nettype wire
